[sv/rbf_pkg.sv]
// shared constants and types for the ray versus box face intersection block
package rbf_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int EXT_W   = 31;
  localparam int THR_W   = 16;
  localparam int DIST_W  = 31;
  localparam int FACE_W  = 3;
  localparam int ADDR_W  = 3;
  localparam int NUM_W   = COORD_W + 3;
  localparam int DIV_LAT = DIST_W + 1;
  localparam int PROD_W  = DIST_W + COORD_W;
  localparam int OFF_W   = PROD_W - FRAC_W;
  localparam int PT_W    = OFF_W + 2;
  localparam int IN_W    = 6 * COORD_W;
  localparam int OUT_W   = ((2 + FACE_W + DIST_W + 7) / 8) * 8;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [ADDR_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [ADDR_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [ADDR_W-1:0] REG_EXT_X = 3'd3;
  localparam logic [ADDR_W-1:0] REG_EXT_Y = 3'd4;
  localparam logic [ADDR_W-1:0] REG_EXT_Z = 3'd5;
  localparam logic [ADDR_W-1:0] REG_THR   = 3'd6;

  localparam logic [FACE_W-1:0] FACE_NONE  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_MAX_Z = 3'd5;

  typedef struct packed {
    logic                    vld;
    logic                    start_in;
    logic [2:0]              skip;
    logic [2:0]              neg;
    logic [2:0][COORD_W-1:0] o;
    logic [2:0][COORD_W-1:0] dm;
  } side_t;

endpackage

[sv/ray_box_face_intersect_top.sv]
// top level: ray against configured axis-aligned box, pipelined one word per cycle while the output is not stalled
// throughput: one ray per cycle while the output is not stalled; the 31-step pipelined divider per axis sets the depth
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, rst_n low) clears all valid bits, box registers to 0, threshold to 1
module ray_box_face_intersect_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // ray_start_x, ray_start_y, ray_start_z, ray_dir_x, ray_dir_y, ray_dir_z
  input  logic [rbf_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // hit, start_inside, hit_face, ray_distance, zero pad
  output logic [rbf_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rbf_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [rbf_pkg::COORD_W-1:0]  cfg_data
);
  import rbf_pkg::*;

  logic en;

  logic [2:0][COORD_W-1:0] min_r;
  logic [2:0][EXT_W-1:0]   ext_r;
  logic [THR_W-1:0]        thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      ext_r <= '0;
      thr_r <= THR_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_MIN_X: min_r[0] <= cfg_data;
        REG_MIN_Y: min_r[1] <= cfg_data;
        REG_MIN_Z: min_r[2] <= cfg_data;
        REG_EXT_X: ext_r[0] <= cfg_data[EXT_W-1:0];
        REG_EXT_Y: ext_r[1] <= cfg_data[EXT_W-1:0];
        REG_EXT_Z: ext_r[2] <= cfg_data[EXT_W-1:0];
        REG_THR:   thr_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a: inside test, plane numerator, skip flags
  side_t                 a_nxt;
  side_t                 a_r;
  logic [2:0][NUM_W-1:0] n_nxt;
  logic [2:0][NUM_W-1:0] n_r;
  logic [2:0]            in_ax;

  always_comb begin
    logic signed [NUM_W-1:0] o, c, hi, plane, num;
    logic [COORD_W-1:0]      dv;
    a_nxt.vld = in_tvalid;
    for (int a = 0; a < 3; a++) begin
      dv = in_tdata[(3+a)*COORD_W +: COORD_W];
      o  = NUM_W'($signed(in_tdata[a*COORD_W +: COORD_W]));
      c  = NUM_W'($signed(min_r[a]));
      hi = c + $signed(NUM_W'(ext_r[a]));
      in_ax[a] = (o >= c) && (o <= hi);
      plane = dv[COORD_W-1] ? hi : c;
      num   = plane - o;
      a_nxt.o[a]   = in_tdata[a*COORD_W +: COORD_W];
      a_nxt.neg[a] = dv[COORD_W-1];
      a_nxt.dm[a]  = dv[COORD_W-1] ? (~dv + 1'b1) : dv;
      a_nxt.skip[a] = (a_nxt.dm[a] <= COORD_W'(thr_r)) ||
                      ((num != '0) && (num[NUM_W-1] != dv[COORD_W-1]));
      n_nxt[a] = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    end
    a_nxt.start_in = &in_ax;
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
      n_r <= n_nxt;
    end
  end

  // divider stages with side data delayed alongside
  logic [2:0][DIST_W-1:0] t_div;
  side_t                  side_r [DIV_LAT];

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbf_udiv u_div (
      .clk (clk),
      .en  (en),
      .n   (n_r[a]),
      .d   (a_r.dm[a]),
      .t   (t_div[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_r[k].vld <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= a_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stage m: t times the other two direction magnitudes
  side_t                        m_r;
  logic [2:0][DIST_W-1:0]       mt_r;
  logic [2:0][1:0][PROD_W-1:0]  prod_r;
  logic [2:0][1:0][PROD_W-1:0]  prod_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_nxt[a][0] = PROD_W'(t_div[a]) * PROD_W'(side_r[DIV_LAT-1].dm[(a+1)%3]);
      prod_nxt[a][1] = PROD_W'(t_div[a]) * PROD_W'(side_r[DIV_LAT-1].dm[(a+2)%3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.vld <= 1'b0;
    end else if (en) begin
      m_r    <= side_r[DIV_LAT-1];
      mt_r   <= t_div;
      prod_r <= prod_nxt;
    end
  end

  // stage c: hit point bounds test per axis
  logic                   c_vld_r;
  logic                   c_inside_r;
  logic [2:0]             c_ok_r;
  logic [2:0]             c_ok_nxt;
  logic [2:0]             c_neg_r;
  logic [2:0][DIST_W-1:0] c_t_r;

  always_comb begin
    logic signed [PT_W-1:0] v, lo, hi, off;
    logic [1:0]             inb;
    int                     j;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 2; k++) begin
        j   = (a + 1 + k) % 3;
        off = $signed(PT_W'(prod_r[a][k][PROD_W-1:FRAC_W]));
        v   = m_r.neg[j] ? PT_W'($signed(m_r.o[j])) - off : PT_W'($signed(m_r.o[j])) + off;
        lo  = PT_W'($signed(min_r[j]));
        hi  = lo + $signed(PT_W'(ext_r[j]));
        inb[k] = (v >= lo) && (v <= hi);
      end
      c_ok_nxt[a] = !m_r.skip[a] && (&inb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r    <= m_r.vld;
      c_inside_r <= m_r.start_in;
      c_ok_r     <= c_ok_nxt;
      c_neg_r    <= m_r.neg;
      c_t_r      <= mt_r;
    end
  end

  // output register: a start inside the box wins, else the first axis in x, y, z order wins
  logic              hit_nxt, ins_nxt;
  logic [FACE_W-1:0] face_nxt;
  logic [DIST_W-1:0] dist_nxt;
  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r;

  always_comb begin
    hit_nxt  = 1'b0;
    ins_nxt  = 1'b0;
    face_nxt = FACE_NONE;
    dist_nxt = '0;
    priority if (c_inside_r) begin
      hit_nxt = 1'b1;
      ins_nxt = 1'b1;
    end else if (c_ok_r[0]) begin
      hit_nxt  = 1'b1;
      face_nxt = FACE_W'({2'd0, c_neg_r[0]});
      dist_nxt = c_t_r[0];
    end else if (c_ok_r[1]) begin
      hit_nxt  = 1'b1;
      face_nxt = FACE_W'({2'd1, c_neg_r[1]});
      dist_nxt = c_t_r[1];
    end else if (c_ok_r[2]) begin
      hit_nxt  = 1'b1;
      face_nxt = FACE_W'({2'd2, c_neg_r[2]});
      dist_nxt = c_t_r[2];
    end else begin
      hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r  <= c_vld_r;
      out_data_r <= OUT_W'({dist_nxt, face_nxt, ins_nxt, hit_nxt});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0] && out_tdata[4:2] == FACE_NONE &&
    out_tdata[35:5] == '0)
    else $error("inside result not a zero-distance hit");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[35:1] == '0)
    else $error("miss with nonzero fields");
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:2] <= FACE_MAX_Z)
    else $error("face code out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(c_vld_r) && $stable(m_r.vld))
    else $error("pipeline moved during stall");
`endif

endmodule

[sv/rbf_udiv.sv]
// pipelined restoring divider: floor(n * 2^FRAC_W / d), saturated to DIST_MAX
module rbf_udiv (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rbf_pkg::NUM_W-1:0]    n,
  input  logic [rbf_pkg::COORD_W-1:0]  d,
  output logic [rbf_pkg::DIST_W-1:0]   t
);
  import rbf_pkg::*;

  localparam int NF_W = NUM_W + FRAC_W;

  typedef struct packed {
    logic               sat;
    logic [DIST_W-1:0]  q;
    logic [COORD_W-1:0] rem;
    logic [DIST_W-1:0]  lo;
    logic [COORD_W-1:0] dm;
  } div_stage_t;

  div_stage_t st_r [DIV_LAT];
  div_stage_t st_nxt [DIV_LAT];
  logic [NF_W-1:0] nf;

  assign nf = {n, {FRAC_W{1'b0}}};

  always_comb begin
    st_nxt[0].sat = NF_W'(n) >= (NF_W'(d) << (DIST_W - FRAC_W));
    st_nxt[0].q   = '0;
    st_nxt[0].rem = COORD_W'(nf >> DIST_W);
    st_nxt[0].lo  = nf[DIST_W-1:0];
    st_nxt[0].dm  = d;
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [COORD_W-1:0] r2;
    logic               ge;
    always_comb begin
      r2 = {st_r[k-1].rem[COORD_W-2:0], st_r[k-1].lo[DIST_W-1]};
      ge = r2 >= st_r[k-1].dm;
      st_nxt[k].sat = st_r[k-1].sat;
      st_nxt[k].q   = {st_r[k-1].q[DIST_W-2:0], ge};
      st_nxt[k].rem = ge ? r2 - st_r[k-1].dm : r2;
      st_nxt[k].lo  = {st_r[k-1].lo[DIST_W-2:0], 1'b0};
      st_nxt[k].dm  = st_r[k-1].dm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign t = st_r[DIV_LAT-1].sat ? DIST_MAX : st_r[DIV_LAT-1].q;

endmodule
